>>> src/idss_pkg.sv
// ----------------------------------------------------------------------------
// Incremental decimal sum store: shared package
// Field widths, item codes, the queued command and the sequencer states.
// ----------------------------------------------------------------------------
package idss_pkg;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 7;
    localparam int DIGIT_W = 4;

    localparam int DIGITS_DEF      = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Input item codes.
    localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RD   = 2'd2;

    localparam logic [DIGIT_W-1:0] DEC_MAX  = 4'd9;
    localparam logic [DIGIT_W:0]   DEC_BASE = 5'd10;

    typedef enum logic [1:0] {
        OP_WR_A,
        OP_WR_B,
        OP_RD
    } idss_op_t;

    typedef struct packed {
        idss_op_t             op;
        logic [POS_W-1:0]     pos;
        logic [DIGIT_W-1:0]   digit;
        logic                 in_range;
    } idss_cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } idss_state_t;

endpackage

>>> src/idss_front.sv
// ----------------------------------------------------------------------------
// Incremental decimal sum store: front end
// Accepts input items, drops those with no effect and turns the rest into
// commands for the queue.
// ----------------------------------------------------------------------------
module idss_front #(
    parameter int DIGITS = idss_pkg::DIGITS_DEF
) (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [idss_pkg::KIND_W-1:0]  kind,
    input  logic [idss_pkg::POS_W-1:0]   position,
    input  logic [idss_pkg::DIGIT_W-1:0] digit,
    input  logic                         clearing,
    input  logic                         push_ready,
    output logic                         push_valid,
    output idss_pkg::idss_cmd_t          push_cmd
);
    import idss_pkg::*;

    logic keep;
    logic wr_ok;

    // Nothing is taken while the stores are being cleared after reset.
    assign in_ready = push_ready && !clearing;

    assign wr_ok = (32'(position) < 32'(DIGITS)) && (digit <= DEC_MAX);

    always_comb
    begin
        keep              = 1'b0;
        push_cmd.op       = OP_RD;
        push_cmd.pos      = position;
        push_cmd.digit    = digit;
        push_cmd.in_range = 1'b0;
        unique case (kind)
            KIND_WR_A:
            begin
                keep              = wr_ok;
                push_cmd.op       = OP_WR_A;
                push_cmd.in_range = wr_ok;
            end
            KIND_WR_B:
            begin
                keep              = wr_ok;
                push_cmd.op       = OP_WR_B;
                push_cmd.in_range = wr_ok;
            end
            KIND_RD:
            begin
                keep              = 1'b1;
                push_cmd.in_range = (32'(position) <= 32'(DIGITS));
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push_valid = in_valid && in_ready && keep;

endmodule

>>> src/idss_queue.sv
// ----------------------------------------------------------------------------
// Incremental decimal sum store: command queue
// A short first-in first-out queue that decouples the front end from the
// sequencer.
// ----------------------------------------------------------------------------
module idss_queue #(
    parameter int DEPTH = idss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  idss_pkg::idss_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop,
    output idss_pkg::idss_cmd_t pop_cmd
);
    import idss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    idss_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count not reduced by a pop");

endmodule

>>> src/idss_back.sv
// ----------------------------------------------------------------------------
// Incremental decimal sum store: sequencer
// Holds the operand and sum memories, applies digit writes with a carry or
// borrow walk, answers reads and clears the memories after reset.
// ----------------------------------------------------------------------------
module idss_back #(
    parameter int DIGITS = idss_pkg::DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  idss_pkg::idss_cmd_t          q_cmd,
    output logic                         clearing,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [idss_pkg::DIGIT_W-1:0] sum_digit
);
    import idss_pkg::*;

    localparam int AW  = $clog2(DIGITS + 1);
    localparam int OAW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [DIGIT_W-1:0] mem_a   [DIGITS];
    logic [DIGIT_W-1:0] mem_b   [DIGITS];
    logic [DIGIT_W-1:0] mem_sum [DIGITS + 1];

    idss_state_t        state_reg, state_next;
    idss_cmd_t          cmd_reg, cmd_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW-1:0]      walk_reg, walk_next;
    logic               up_reg, up_next;
    logic               out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0] sum_digit_reg, sum_digit_next;

    logic               a_we, b_we, s_we, op_re, s_re;
    logic [OAW-1:0]     op_waddr, op_raddr;
    logic [AW-1:0]      s_waddr, s_raddr;
    logic [DIGIT_W-1:0] op_wdata, s_wdata;
    logic [DIGIT_W-1:0] a_q, b_q, s_q;

    logic [AW-1:0]      cmd_addr;
    logic [DIGIT_W-1:0] old_digit;
    logic [DIGIT_W:0]   part_sum;
    logic [DIGIT_W:0]   diff;

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign sum_digit = sum_digit_reg;

    assign cmd_addr  = AW'(cmd_reg.pos);
    assign old_digit = (cmd_reg.op == OP_WR_A) ? a_q : b_q;
    assign part_sum  = {1'b0, s_q} + {1'b0, cmd_reg.digit};
    assign diff      = part_sum - {1'b0, old_digit};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        clr_next       = clr_reg;
        walk_next      = walk_reg;
        up_next        = up_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sum_digit_next = sum_digit_reg;
        q_pop          = 1'b0;
        a_we           = 1'b0;
        b_we           = 1'b0;
        s_we           = 1'b0;
        op_re          = 1'b0;
        s_re           = 1'b0;
        op_waddr       = OAW'(cmd_addr);
        op_raddr       = OAW'(q_cmd.pos);
        op_wdata       = cmd_reg.digit;
        s_waddr        = cmd_addr;
        s_raddr        = AW'(q_cmd.pos);
        s_wdata        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                a_we     = (clr_reg < AW'(DIGITS));
                b_we     = (clr_reg < AW'(DIGITS));
                op_waddr = OAW'(clr_reg);
                op_wdata = '0;
                s_we     = 1'b1;
                s_waddr  = clr_reg;
                if (clr_reg == AW'(DIGITS))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    op_re      = 1'b1;
                    s_re       = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg.op == OP_RD)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_next = 1'b1;
                        sum_digit_next = cmd_reg.in_range ? s_q : '0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    a_we       = (cmd_reg.op == OP_WR_A);
                    b_we       = (cmd_reg.op == OP_WR_B);
                    s_we       = 1'b1;
                    state_next = ST_IDLE;
                    // A write always sits below the top sum digit, so a
                    // carry or borrow always has a digit to walk into.
                    if (part_sum < {1'b0, old_digit})
                    begin
                        s_wdata    = DIGIT_W'(part_sum + DEC_BASE - {1'b0, old_digit});
                        up_next    = 1'b0;
                        walk_next  = cmd_addr + 1'b1;
                        s_re       = 1'b1;
                        s_raddr    = cmd_addr + 1'b1;
                        state_next = ST_WALK;
                    end
                    else if (diff > {1'b0, DEC_MAX})
                    begin
                        s_wdata    = DIGIT_W'(diff - DEC_BASE);
                        up_next    = 1'b1;
                        walk_next  = cmd_addr + 1'b1;
                        s_re       = 1'b1;
                        s_raddr    = cmd_addr + 1'b1;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        s_wdata = DIGIT_W'(diff);
                    end
                end
            end
            ST_WALK:
            begin
                s_we       = 1'b1;
                s_waddr    = walk_reg;
                state_next = ST_IDLE;
                if ((up_reg && s_q == DEC_MAX) || (!up_reg && s_q == '0))
                begin
                    s_wdata = up_reg ? '0 : DEC_MAX;
                    // The walk is dropped once it passes the top digit.
                    if (walk_reg != AW'(DIGITS))
                    begin
                        walk_next  = walk_reg + 1'b1;
                        s_re       = 1'b1;
                        s_raddr    = walk_reg + 1'b1;
                        state_next = ST_WALK;
                    end
                end
                else
                begin
                    s_wdata = up_reg ? s_q + 1'b1 : s_q - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        walk_reg      <= walk_next;
        up_reg        <= up_next;
        sum_digit_reg <= sum_digit_next;
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[op_waddr] <= op_wdata;
        end
        if (op_re)
        begin
            a_q <= mem_a[op_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[op_waddr] <= op_wdata;
        end
        if (op_re)
        begin
            b_q <= mem_b[op_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            mem_sum[s_waddr] <= s_wdata;
        end
        if (s_re)
        begin
            s_q <= mem_sum[s_raddr];
        end
    end

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> walk_reg <= AW'(DIGITS) && walk_reg != '0)
        else $error("carry walk outside the sum digits");

    a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !q_valid)
        else $error("command queued during clearing pass");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> sum_digit_reg <= DEC_MAX)
        else $error("result digit not decimal");

endmodule

>>> src/incremental_decimal_sum_store_unit.sv
// ----------------------------------------------------------------------------
// Incremental decimal sum store
// Two decimal operands and their sum, updated one digit at a time.
//
//   channel   direction   handshake             payload
//   input     in          in_valid / in_ready   kind, position, digit
//   result    out         out_valid / out_ready sum_digit
//
// In the sequencer a read is popped and addresses the sum memory in ST_IDLE,
// and loads the result register in ST_EXEC. A write passes ST_IDLE and ST_EXEC,
// then walks the carry or borrow through the sum digits in ST_WALK, one per
// cycle through the sum memory's single read and write port.
// After reset a clearing pass zeroes the memories, and in_ready stays low
// during it. Ignored items are dropped at the front end.
// While a result waits for out_ready, writes still go ahead. A further read
// holds the sequencer, and in_ready drops once the two-entry queue is full.
// ----------------------------------------------------------------------------
module incremental_decimal_sum_store_unit #(
    parameter int DIGITS      = idss_pkg::DIGITS_DEF,
    parameter int QUEUE_DEPTH = idss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [idss_pkg::KIND_W-1:0]  kind,
    input  logic [idss_pkg::POS_W-1:0]   position,
    input  logic [idss_pkg::DIGIT_W-1:0] digit,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [idss_pkg::DIGIT_W-1:0] sum_digit
);
    import idss_pkg::*;

    idss_cmd_t push_cmd;
    idss_cmd_t pop_cmd;
    logic      push_valid;
    logic      push_ready;
    logic      pop_valid;
    logic      pop;
    logic      clearing;

    idss_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .position   (position),
        .digit      (digit),
        .clearing   (clearing),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    idss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    idss_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_pop     (pop),
        .q_cmd     (pop_cmd),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum_digit (sum_digit)
    );

endmodule

>>> verif/tb_incremental_decimal_sum_store_unit.sv
// ----------------------------------------------------------------------------
// Testbench: incremental decimal sum store
// Operand digit writes and sum digit reads are driven through a queue of
// pending items. A shadow copy of both operands and the sum predicts every
// read, and each returned sum digit is checked against the oldest prediction.
// Traffic runs in phases with and without idling on either side.
// ----------------------------------------------------------------------------
module tb_incremental_decimal_sum_store_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import idss_pkg::*;

    localparam int DIGITS = DIGITS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 270;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [DIGIT_W-1:0] digit;
    } digit_item_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [KIND_W-1:0]  kind      = '0;
    logic [POS_W-1:0]   position  = '0;
    logic [DIGIT_W-1:0] digit     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DIGIT_W-1:0] sum_digit;

    digit_item_t        pending_items[$];
    logic [DIGIT_W-1:0] sum_digits_due[$];

    logic [DIGIT_W-1:0] first_operand  [DIGITS];
    logic [DIGIT_W-1:0] second_operand [DIGITS];
    logic [DIGIT_W-1:0] sum_store      [DIGITS + 1];

    logic item_taken     = 1'b0;
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    int   stall_cycles    = 0;
    int   mismatch_count  = 0;

    incremental_decimal_sum_store_unit #(
        .DIGITS (DIGITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .position  (position),
        .digit     (digit),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum_digit (sum_digit)
    );

    always #10 clk = ~clk;

    task automatic push_item(input logic [KIND_W-1:0] k, input int p, input int d);
        digit_item_t item;
        item.kind     = k;
        item.position = POS_W'(p);
        item.digit    = DIGIT_W'(d);
        pending_items.push_back(item);
    endtask

    // Updates the shadow operands and sum for one accepted item, and queues
    // the sum digit that a read must return.
    task automatic apply_item_to_sum(input logic [KIND_W-1:0] k,
                                     input logic [POS_W-1:0] p,
                                     input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] old_digit;
        int t;
        int i;
        if (k == KIND_RD) begin
            sum_digits_due.push_back((p <= DIGITS) ? sum_store[p] : DIGIT_W'(0));
        end
        else if ((k == KIND_WR_A || k == KIND_WR_B) && p < DIGITS && d <= DEC_MAX) begin
            if (k == KIND_WR_A) begin
                old_digit = first_operand[p];
                first_operand[p] = d;
            end
            else begin
                old_digit = second_operand[p];
                second_operand[p] = d;
            end
            t = int'(sum_store[p]) + int'(d) - int'(old_digit);
            i = int'(p) + 1;
            if (t > int'(DEC_MAX)) begin
                sum_store[p] = DIGIT_W'(t - int'(DEC_BASE));
                while (i <= DIGITS && sum_store[i] == DEC_MAX) begin
                    sum_store[i] = '0;
                    i++;
                end
                if (i <= DIGITS)
                    sum_store[i] = sum_store[i] + 1'b1;
            end
            else if (t < 0) begin
                sum_store[p] = DIGIT_W'(t + int'(DEC_BASE));
                while (i <= DIGITS && sum_store[i] == '0) begin
                    sum_store[i] = DEC_MAX;
                    i++;
                end
                if (i <= DIGITS)
                    sum_store[i] = sum_store[i] - 1'b1;
            end
            else begin
                sum_store[p] = DIGIT_W'(t);
            end
        end
    endtask

    // Monitor: checks results and predicts accepted items at the rising edge.
    always @(posedge clk)
    begin
        logic progress;
        logic [DIGIT_W-1:0] due;
        progress = 1'b0;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                progress = 1'b1;
                if (sum_digits_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: sum digit %0d returned, expected none", $time, sum_digit);
                end
                else begin
                    due = sum_digits_due.pop_front();
                    if (sum_digit !== due) begin
                        mismatch_count++;
                        $display("%0t: sum digit mismatch, expected %0d, actual %0d",
                                 $time, due, sum_digit);
                    end
                end
            end
            if (in_valid && in_ready) begin
                progress = 1'b1;
                item_taken = 1'b1;
                apply_item_to_sum(kind, position, digit);
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
        end
    end

    // Driver: presents the next pending item and sets out_ready at the falling edge.
    always @(negedge clk)
    begin
        digit_item_t next_item;
        if (!in_valid || item_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                next_item = pending_items.pop_front();
                in_valid <= 1'b1;
                kind     <= next_item.kind;
                position <= next_item.position;
                digit    <= next_item.digit;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
        item_taken = 1'b0;
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int phase;
        int count;
        int roll;
        int lo;
        int hi;
        int span;
        int p;
        int d;
        logic [KIND_W-1:0] k;
        logic [KIND_W-1:0] nines_kind;
        logic [KIND_W-1:0] zeros_kind;

        for (int n = 0; n < DIGITS; n++) begin
            first_operand[n]  = '0;
            second_operand[n] = '0;
        end
        for (int n = 0; n <= DIGITS; n++)
            sum_store[n] = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Carry and borrow at the bottom and at the top digit, ignored writes,
        // reads past the top of the sum and the unused kind.
        push_item(KIND_RD,      0,          0);
        push_item(KIND_WR_A,    0,          9);
        push_item(KIND_WR_B,    0,          9);
        push_item(KIND_RD,      0,          0);
        push_item(KIND_RD,      1,          15);
        push_item(KIND_WR_A,    0,          0);
        push_item(KIND_RD,      1,          0);
        push_item(KIND_WR_A,    DIGITS - 1, 9);
        push_item(KIND_WR_B,    DIGITS - 1, 9);
        push_item(KIND_RD,      DIGITS,     0);
        push_item(KIND_RD,      DIGITS - 1, 0);
        push_item(KIND_WR_A,    DIGITS,     5);
        push_item(KIND_WR_B,    127,        9);
        push_item(KIND_WR_A,    5,          15);
        push_item(KIND_WR_B,    5,          10);
        push_item(KIND_RD,      DIGITS + 1, 0);
        push_item(KIND_RD,      127,        15);
        push_item(KIND_UNUSED,  5,          5);
        push_item(KIND_UNUSED,  127,        15);
        push_item(KIND_RD,      5,          0);
        push_item(KIND_WR_B,    DIGITS - 1, 0);
        push_item(KIND_RD,      DIGITS,     0);
        push_item(KIND_RD,      DIGITS - 1, 0);
        push_item(KIND_RD,      0,          0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 2) begin
                    // Build a run of digit pairs summing to nine, then push a
                    // carry through it and pull it back with a borrow.
                    lo = $urandom_range(0, DIGITS - 2);
                    if ($urandom_range(0, 4) == 0)
                        span = DIGITS - 1 - lo;
                    else
                        span = $urandom_range(1, (DIGITS - 1 - lo < 12) ? DIGITS - 1 - lo : 12);
                    hi = lo + span;
                    nines_kind = ($urandom_range(0, 1) != 0) ? KIND_WR_A : KIND_WR_B;
                    zeros_kind = (nines_kind == KIND_WR_A) ? KIND_WR_B : KIND_WR_A;
                    for (int n = lo; n <= hi; n++) begin
                        push_item(nines_kind, n, 9);
                        push_item(zeros_kind, n, 0);
                    end
                    push_item(zeros_kind, lo, 1);
                    push_item(KIND_RD, hi + 1, $urandom_range(0, 15));
                    push_item(KIND_RD, $urandom_range(lo, hi), $urandom_range(0, 15));
                    push_item(zeros_kind, lo, 0);
                    push_item(KIND_RD, hi + 1, $urandom_range(0, 15));
                    push_item(KIND_RD, $urandom_range(lo, hi), $urandom_range(0, 15));
                    count += 2 * (span + 1) + 6;
                end
                else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        k = KIND_UNUSED;
                    else if (roll < 33)
                        k = KIND_RD;
                    else if (roll < 68)
                        k = KIND_WR_A;
                    else
                        k = KIND_WR_B;
                    roll = $urandom_range(0, 99);
                    if (roll < 85)
                        p = $urandom_range(0, DIGITS - 1);
                    else if (roll < 90)
                        p = DIGITS;
                    else
                        p = $urandom_range(0, (1 << POS_W) - 1);
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        d = ($urandom_range(0, 1) != 0) ? int'(DEC_MAX) : 0;
                    else if (roll < 92)
                        d = $urandom_range(0, int'(DEC_MAX));
                    else
                        d = $urandom_range(int'(DEC_BASE), (1 << DIGIT_W) - 1);
                    push_item(k, p, d);
                    count++;
                end
            end
            while (pending_items.size() != 0 || in_valid || sum_digits_due.size() != 0)
                @(posedge clk);
        end

        // A final write may still be walking its carry through the sum.
        repeat (2 * DIGITS + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
